// ===== hdl/hsu_pkg.sv =====
// Package for the escaped string decoder: word types, result codes and name tables.
package hsu_pkg;

	localparam int Q_DEPTH = 4;
	localparam int MAX_RES = 3;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_ERR  = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_AMP       = 8'h26;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_ONE       = 8'h31;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_Z   = 8'h5A;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       run_end;
	} out_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} result_t;

	// results caused by one character, res[0] first
	typedef struct packed {
		logic [1:0]                cnt;
		result_t [MAX_RES-1:0]     res;
	} bundle_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} lookup_t;

	function automatic lookup_t one_lookup(input logic [7:0] c);
		lookup_t r;
		r.hit = 1'b1;
		case (c)
			8'h30: r.code = 8'h00;
			8'h61: r.code = 8'h07;
			8'h62: r.code = 8'h08;
			8'h66: r.code = 8'h0C;
			8'h6E: r.code = 8'h0A;
			8'h72: r.code = 8'h0D;
			8'h74: r.code = 8'h09;
			8'h76: r.code = 8'h0B;
			8'h22: r.code = 8'h22;
			8'h27: r.code = 8'h27;
			8'h5C: r.code = 8'h5C;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic lookup_t two_lookup(input logic [7:0] a, input logic [7:0] b);
		lookup_t r;
		r.hit = 1'b1;
		case ({a, b})
			16'h4253: r.code = 8'h08;
			16'h4854: r.code = 8'h09;
			16'h4C46: r.code = 8'h0A;
			16'h5654: r.code = 8'h0B;
			16'h4646: r.code = 8'h0C;
			16'h4352: r.code = 8'h0D;
			16'h534F: r.code = 8'h0E;
			16'h5349: r.code = 8'h0F;
			16'h454D: r.code = 8'h19;
			16'h4653: r.code = 8'h1C;
			16'h4753: r.code = 8'h1D;
			16'h5253: r.code = 8'h1E;
			16'h5553: r.code = 8'h1F;
			16'h5350: r.code = 8'h20;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic logic three_prefix(input logic [7:0] a, input logic [7:0] b);
		logic r;
		case ({a, b}) inside
			16'h4E55, 16'h534F, 16'h5354, 16'h4554, 16'h454F, 16'h454E,
			16'h4143, 16'h4245, 16'h444C, 16'h4443, 16'h4E41, 16'h5359,
			16'h4341, 16'h5355, 16'h4553, 16'h4445: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic lookup_t three_lookup(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		lookup_t r;
		r.hit = 1'b1;
		case ({a, b, c})
			24'h4E554C: r.code = 8'h00;
			24'h534F48: r.code = 8'h01;
			24'h535458: r.code = 8'h02;
			24'h455458: r.code = 8'h03;
			24'h454F54: r.code = 8'h04;
			24'h454E51: r.code = 8'h05;
			24'h41434B: r.code = 8'h06;
			24'h42454C: r.code = 8'h07;
			24'h444C45: r.code = 8'h10;
			24'h444331: r.code = 8'h11;
			24'h444332: r.code = 8'h12;
			24'h444333: r.code = 8'h13;
			24'h444334: r.code = 8'h14;
			24'h4E414B: r.code = 8'h15;
			24'h53594E: r.code = 8'h16;
			24'h455442: r.code = 8'h17;
			24'h43414E: r.code = 8'h18;
			24'h535542: r.code = 8'h1A;
			24'h455343: r.code = 8'h1B;
			24'h44454C: r.code = 8'h7F;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/haskell_string_unescape.sv =====
// Top level of the escaped string decoder: front end, bundle queue, back end.
//
// chr channel: one character word per cycle (ch, last); the block stalls it
// only when the bundle queue is full.
// res channel: one result word per cycle unless stalled (kind, value,
// run_end); run_end marks the final result caused by one character. A
// character that ends a string always yields an end word; after an error
// word the rest of the string is dropped up to its last character.
// Each character's results are registered in the bundle queue first.
// Throughput: one character per cycle while each yields at most one result
// and the receiver does not stall; the output side sends one word per cycle
// unless stalled, one per result, and the QDEPTH-bundle queue absorbs bursts.
// Reset clears the decoder state and empties the queue; no sweep follows.
// When the receiver stalls, the current word holds and the queue fills; once
// full, the chr channel stalls.
module haskell_string_unescape import hsu_pkg::*; #(
	parameter int QDEPTH = Q_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      chr_valid,
	output logic      chr_stall,
	input  in_word_t  chr_word,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res_word
);

	logic      push, pop;
	bundle_t   bundle, head;
	q_status_t status;

	hsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (chr_valid),
		.word   (chr_word),
		.q_full (status.full),
		.stall  (chr_stall),
		.push   (push),
		.bundle (bundle)
	);

	hsu_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (bundle),
		.pop     (pop),
		.head    (head),
		.status  (status)
	);

	hsu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.status (status),
		.stall  (res_stall),
		.valid  (res_valid),
		.word   (res_word),
		.pop    (pop)
	);

endmodule

// ===== hdl/hsu_front.sv =====
// Front end: accepts characters, runs the escape state machine, builds result bundles.
module hsu_front import hsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid,
	input  in_word_t  word,
	input  logic      q_full,
	output logic      stall,
	output logic      push,
	output bundle_t   bundle
);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_ESC  = 3'd1;
	localparam logic [2:0] M_DEC  = 3'd2;
	localparam logic [2:0] M_L1   = 3'd3;
	localparam logic [2:0] M_L2   = 3'd4;

	logic [2:0] mode_q, mode_d;
	logic [7:0] acc_q, acc_d;
	logic [7:0] b0_q, b0_d;
	logic [7:0] b1_q, b1_d;
	logic       err_q, err_d;

	result_t [MAX_RES-1:0] res;
	logic [1:0] n;
	logic       plain;
	logic [7:0] c;
	logic       is_digit;
	lookup_t    one_r, two_c, two_h, two_f, three_r;
	logic       pre_r;
	logic       take;

	assign c     = word.ch;
	assign stall = q_full;
	assign take  = valid && !q_full;

	always_comb begin
		mode_d   = mode_q;
		acc_d    = acc_q;
		b0_d     = b0_q;
		b1_d     = b1_q;
		err_d    = err_q;
		res      = '0;
		n        = 2'd0;
		plain    = 1'b0;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		one_r    = one_lookup(c);
		two_c    = two_lookup(b0_q, c);
		two_h    = two_lookup(b0_q, b1_q);
		three_r  = three_lookup(b0_q, b1_q, c);
		pre_r    = three_prefix(b0_q, c);
		if (!err_q) begin
			unique case (mode_q)
				M_ESC: begin
					if (c == CH_AMP) begin
						mode_d = M_IDLE;
					end else if ((c >= CH_ONE) && (c <= CH_NINE)) begin
						acc_d  = c - CH_ZERO;
						mode_d = M_DEC;
					end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) begin
						b0_d   = c;
						mode_d = M_L1;
					end else if (one_r.hit) begin
						res[n] = '{KIND_BYTE, one_r.code};
						n      = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						res[n] = '{KIND_ERR, 8'h00};
						n      = n + 2'd1;
						mode_d = M_IDLE;
						err_d  = 1'b1;
					end
				end
				M_DEC: begin
					if (is_digit) begin
						acc_d = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + (c - CH_ZERO);
					end else begin
						res[n] = '{KIND_BYTE, acc_q};
						n      = n + 2'd1;
						plain  = 1'b1;
					end
				end
				M_L1: begin
					if (pre_r) begin
						b1_d   = c;
						mode_d = M_L2;
					end else if (two_c.hit) begin
						res[n] = '{KIND_BYTE, two_c.code};
						n      = n + 2'd1;
						mode_d = M_IDLE;
					end else begin
						res[n] = '{KIND_ERR, 8'h00};
						n      = n + 2'd1;
						mode_d = M_IDLE;
						err_d  = 1'b1;
					end
				end
				M_L2: begin
					if (three_r.hit) begin
						res[n] = '{KIND_BYTE, three_r.code};
						n      = n + 2'd1;
						mode_d = M_IDLE;
					end else if (two_h.hit) begin
						res[n] = '{KIND_BYTE, two_h.code};
						n      = n + 2'd1;
						plain  = 1'b1;
					end else begin
						res[n] = '{KIND_ERR, 8'h00};
						n      = n + 2'd1;
						mode_d = M_IDLE;
						err_d  = 1'b1;
					end
				end
				default: plain = 1'b1;
			endcase
			if (plain) begin
				if (c == CH_BACKSLASH) begin
					mode_d = M_ESC;
				end else begin
					res[n] = '{KIND_BYTE, c};
					n      = n + 2'd1;
					mode_d = M_IDLE;
				end
			end
			// end of string: flush an open decimal or name escape; a lone backslash is dropped
			two_f = two_lookup(b0_d, b1_d);
			if (word.last && !err_d) begin
				if (mode_d == M_DEC) begin
					res[n] = '{KIND_BYTE, acc_d};
					n      = n + 2'd1;
				end else if (mode_d == M_L1 || (mode_d == M_L2 && !two_f.hit)) begin
					res[n] = '{KIND_ERR, 8'h00};
					n      = n + 2'd1;
					err_d  = 1'b1;
				end else if (mode_d == M_L2) begin
					res[n] = '{KIND_BYTE, two_f.code};
					n      = n + 2'd1;
				end
				mode_d = M_IDLE;
			end
		end else begin
			two_f = two_lookup(b0_q, b1_q);
		end
		if (word.last) begin
			res[n] = '{KIND_END, 8'h00};
			n      = n + 2'd1;
			mode_d = M_IDLE;
			acc_d  = 8'h00;
			b0_d   = 8'h00;
			b1_d   = 8'h00;
			err_d  = 1'b0;
		end
	end

	assign bundle.cnt = n;
	assign bundle.res = res;
	assign push       = take && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			acc_q  <= 8'h00;
			b0_q   <= 8'h00;
			b1_q   <= 8'h00;
			err_q  <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			b0_q   <= b0_d;
			b1_q   <= b1_d;
			err_q  <= err_d;
		end
	end

endmodule

// ===== hdl/hsu_queue.sv =====
// Short bundle queue between front and back ends.
module hsu_queue import hsu_pkg::*; #(
	parameter int DEPTH = Q_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bundle_t   wr_data,
	input  logic      pop,
	output bundle_t   head,
	output q_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bundle_t       entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head         = entries_q[rd_ptr_q];
	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/hsu_back.sv =====
// Back end: walks the head bundle and sends its results one word per cycle unless stalled.
module hsu_back import hsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  bundle_t   head,
	input  q_status_t status,
	input  logic      stall,
	output logic      valid,
	output out_word_t word,
	output logic      pop
);

	logic [1:0] idx_q;
	logic       last_one;
	logic       send;

	assign valid        = !status.empty;
	assign last_one     = (idx_q == head.cnt - 2'd1);
	assign send         = valid && !stall;
	assign pop          = send && last_one;
	assign word.kind    = head.res[idx_q].kind;
	assign word.value   = head.res[idx_q].value;
	assign word.run_end = last_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (send) begin
			idx_q <= last_one ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== tb/hsu_decode_check.sv =====
// Checker for the escaped string decoder: predicts result words per character and compares.
module hsu_decode_check import hsu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      chr_valid,
	input  logic      chr_stall,
	input  in_word_t  chr_word,
	input  logic      res_valid,
	input  logic      res_stall,
	input  out_word_t res_word,
	output int        fail_count,
	output int        outstanding,
	output int        chars_taken,
	output int        words_checked,
	output int        err_words
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {S_PLAIN, S_ESC, S_DEC, S_LETTER1, S_LETTER2} scan_state_e;

	localparam logic [7:0] ESC_CHARS [11] = '{"0", "a", "b", "f", "n", "r", "t", "v",
		"\"", "'", "\\"};
	localparam logic [7:0] ESC_CODES [11] = '{8'h00, 8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D,
		8'h09, 8'h0B, 8'h22, 8'h27, 8'h5C};
	localparam logic [15:0] DUO_NAMES [14] = '{"BS", "HT", "LF", "VT", "FF", "CR", "SO",
		"SI", "EM", "FS", "GS", "RS", "US", "SP"};
	localparam logic [7:0] DUO_CODES [14] = '{8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
		8'h0E, 8'h0F, 8'h19, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20};
	localparam logic [23:0] TRIO_NAMES [20] = '{"NUL", "SOH", "STX", "ETX", "EOT", "ENQ",
		"ACK", "BEL", "DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB", "CAN",
		"SUB", "ESC", "DEL"};
	localparam logic [7:0] TRIO_CODES [20] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
		8'h06, 8'h07, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18,
		8'h1A, 8'h1B, 8'h7F};

	scan_state_e st;
	logic [7:0]  dec_acc;
	logic [7:0]  held [2];
	logic        dropping;
	out_word_t   char_results [$];
	out_word_t   pending_results [$];
	int          n_fail;
	int          n_chars;
	int          n_words;
	int          n_err;

	function automatic logic esc_hit(input logic [7:0] c, output logic [7:0] code);
		int i;
		code = 8'h00;
		for (i = 0; i < 11; i++)
			if (ESC_CHARS[i] == c) begin
				code = ESC_CODES[i];
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic logic duo_hit(input logic [7:0] a, input logic [7:0] b,
			output logic [7:0] code);
		int i;
		code = 8'h00;
		for (i = 0; i < 14; i++)
			if (DUO_NAMES[i] == {a, b}) begin
				code = DUO_CODES[i];
				return 1'b1;
			end
		return 1'b0;
	endfunction

	function automatic logic trio_prefix(input logic [7:0] a, input logic [7:0] b);
		int i;
		for (i = 0; i < 20; i++)
			if (TRIO_NAMES[i][23:8] == {a, b})
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic trio_hit(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, output logic [7:0] code);
		int i;
		code = 8'h00;
		for (i = 0; i < 20; i++)
			if (TRIO_NAMES[i] == {a, b, c}) begin
				code = TRIO_CODES[i];
				return 1'b1;
			end
		return 1'b0;
	endfunction

	// at most MAX_RES words per character
	task automatic note(input logic [1:0] k, input logic [7:0] v);
		out_word_t w;
		if (char_results.size() < MAX_RES) begin
			w.kind = k;
			w.value = (k == KIND_BYTE) ? v : 8'h00;
			w.run_end = 1'b0;
			char_results = {char_results, w};
		end
	endtask

	task automatic bad_escape();
		note(KIND_ERR, 8'h00);
		st = S_PLAIN;
		dropping = 1'b1;
	endtask

	task automatic plain_char(input logic [7:0] c);
		if (c == CH_BACKSLASH)
			st = S_ESC;
		else
			note(KIND_BYTE, c);
	endtask

	task automatic decode_char(input logic [7:0] c);
		logic [7:0] code;
		case (st)
			S_ESC: begin
				if (c == CH_AMP) begin
					st = S_PLAIN;
				end else if (c >= CH_ONE && c <= CH_NINE) begin
					dec_acc = c - CH_ZERO;
					st = S_DEC;
				end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
					held[0] = c;
					st = S_LETTER1;
				end else if (esc_hit(c, code)) begin
					note(KIND_BYTE, code);
					st = S_PLAIN;
				end else begin
					bad_escape();
				end
			end
			S_DEC: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					dec_acc = 8'(dec_acc * 8'd10 + (c - CH_ZERO));
				end else begin
					note(KIND_BYTE, dec_acc);
					st = S_PLAIN;
					plain_char(c);
				end
			end
			S_LETTER1: begin
				if (trio_prefix(held[0], c)) begin
					held[1] = c;
					st = S_LETTER2;
				end else if (duo_hit(held[0], c, code)) begin
					note(KIND_BYTE, code);
					st = S_PLAIN;
				end else begin
					bad_escape();
				end
			end
			S_LETTER2: begin
				if (trio_hit(held[0], held[1], c, code)) begin
					note(KIND_BYTE, code);
					st = S_PLAIN;
				end else if (duo_hit(held[0], held[1], code)) begin
					// shorter name wins, char goes through as plain
					note(KIND_BYTE, code);
					st = S_PLAIN;
					plain_char(c);
				end else begin
					bad_escape();
				end
			end
			default: begin
				st = S_PLAIN;
				plain_char(c);
			end
		endcase
	endtask

	task automatic flush_pending();
		logic [7:0] code;
		if (st == S_DEC)
			note(KIND_BYTE, dec_acc);
		else if (st == S_LETTER1)
			bad_escape();
		else if (st == S_LETTER2) begin
			if (duo_hit(held[0], held[1], code))
				note(KIND_BYTE, code);
			else
				bad_escape();
		end
		st = S_PLAIN;
	endtask

	task automatic clear_state();
		st = S_PLAIN;
		dec_acc = 8'h00;
		held[0] = 8'h00;
		held[1] = 8'h00;
		dropping = 1'b0;
	endtask

	task automatic predict_char(input in_word_t w);
		char_results.delete();
		if (!dropping) begin
			decode_char(w.ch);
			if (w.last && !dropping)
				flush_pending();
		end
		if (w.last) begin
			note(KIND_END, 8'h00);
			clear_state();
		end
		if (char_results.size() > 0)
			char_results[char_results.size() - 1].run_end = 1'b1;
		pending_results = {pending_results, char_results};
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			clear_state();
			pending_results.delete();
			n_fail = 0;
			n_chars = 0;
			n_words = 0;
			n_err = 0;
		end else begin
			if (res_valid && !res_stall) begin
				n_words++;
				if (res_word.kind == KIND_ERR)
					n_err++;
				if (pending_results.size() == 0) begin
					n_fail++;
					$error("unexpected word: kind %0d value 0x%02h run_end %0b",
						res_word.kind, res_word.value, res_word.run_end);
				end else begin
					want = pending_results.pop_front();
					if (res_word.kind !== want.kind) begin
						n_fail++;
						$error("kind: expected %0d, actual %0d", want.kind, res_word.kind);
					end
					if (res_word.value !== want.value) begin
						n_fail++;
						$error("value: expected 0x%02h, actual 0x%02h", want.value,
							res_word.value);
					end
					if (res_word.run_end !== want.run_end) begin
						n_fail++;
						$error("run_end: expected %0b, actual %0b", want.run_end,
							res_word.run_end);
					end
				end
			end
			if (chr_valid && !chr_stall) begin
				n_chars++;
				predict_char(chr_word);
			end
		end
		fail_count <= n_fail;
		outstanding <= pending_results.size();
		chars_taken <= n_chars;
		words_checked <= n_words;
		err_words <= n_err;
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the escaped string decoder testbench: clock, reset, character strings and verdict.
module tb_top import hsu_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 60;
	localparam int QUIET_LIMIT = 2000;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      chr_valid = 1'b0;
	logic      chr_stall;
	in_word_t  chr_word = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_word_t res_word;

	int fail_count;
	int outstanding;
	int chars_taken;
	int words_checked;
	int err_words;

	logic       calm = 1'b0;
	logic       hold_req = 1'b0;
	logic       hold_active = 1'b0;
	int         quiet = 0;
	int         chars_sent = 0;
	int         strings_sent = 0;
	logic [7:0] text [$];

	string esc_letters = "0abfnrtv\"'\\";
	string duo_list [14] = '{"BS", "HT", "LF", "VT", "FF", "CR", "SO", "SI", "EM", "FS",
		"GS", "RS", "US", "SP"};
	string trio_list [20] = '{"NUL", "SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "BEL",
		"DLE", "DC1", "DC2", "DC3", "DC4", "NAK", "SYN", "ETB", "CAN", "SUB", "ESC",
		"DEL"};

	haskell_string_unescape DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr_word  (chr_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	hsu_decode_check decode_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.chr_valid     (chr_valid),
		.chr_stall     (chr_stall),
		.chr_word      (chr_word),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_word      (res_word),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.chars_taken   (chars_taken),
		.words_checked (words_checked),
		.err_words     (err_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	task automatic put_char(input logic [7:0] c, input logic l);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			chr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chr_valid <= 1'b1;
		chr_word <= '{ch: c, last: l};
		do @(posedge clk); while (chr_stall);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text[i])
			put_char(text[i], i == text.size() - 1);
		strings_sent++;
	endtask

	task automatic text_add(input logic [7:0] c);
		text = {text, c};
	endtask

	task automatic add_str(input string s);
		foreach (s[i])
			text_add(s[i]);
	endtask

	task automatic send_str(input string s);
		text.delete();
		add_str(s);
		send_text();
	endtask

	task automatic drain();
		chr_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic add_piece();
		int r;
		int n;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			do begin
				if ($urandom_range(0, 1))
					c = 8'($urandom_range(32, 126));
				else
					c = 8'($urandom);
			end while (c == CH_BACKSLASH);
			text_add(c);
		end else if (r < 47) begin
			text_add(CH_BACKSLASH);
			text_add(esc_letters[$urandom_range(0, 10)]);
		end else if (r < 52) begin
			add_str("\\&");
		end else if (r < 64) begin
			text_add(CH_BACKSLASH);
			text_add(8'(CH_ONE + $urandom_range(0, 8)));
			n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			repeat (n) text_add(8'(CH_ZERO + $urandom_range(0, 9)));
		end else if (r < 74) begin
			add_str({"\\", duo_list[$urandom_range(0, 13)]});
		end else if (r < 86) begin
			add_str({"\\", trio_list[$urandom_range(0, 19)]});
		end else if (r < 90) begin
			add_str("\\SO");
		end else if (r < 96) begin
			text_add(CH_BACKSLASH);
			text_add(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
			text_add(8'($urandom));
		end else begin
			text_add(CH_BACKSLASH);
			text_add(8'($urandom));
		end
	endtask

	task automatic send_random_string();
		int n;
		text.delete();
		if ($urandom_range(0, 9) == 0) begin
			// noise, heavy on backslashes
			n = $urandom_range(1, 10);
			repeat (n) begin
				if ($urandom_range(0, 9) < 3)
					text_add(CH_BACKSLASH);
				else
					text_add(8'($urandom));
			end
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
			repeat (n) add_piece();
			if ($urandom_range(0, 19) == 0)
				text_add(CH_BACKSLASH);
		end
		send_text();
	endtask

	// output side: random stalls, calm stretches, and one long hold on request
	initial begin
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_active = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				hold_req = 1'b0;
			end else if (calm) begin
				res_stall <= 1'b0;
				@(posedge clk);
			end else begin
				res_stall <= ($urandom_range(0, 2) == 0);
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (chr_valid && !chr_stall) || (res_valid && !res_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("haskell_string_unescape verification failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		text.delete();
		text_add(8'h00);
		add_str("\\&\\\\");
		text_add(8'hFF);
		send_text();
		send_str("\\1234");
		send_str("\\SOH");
		send_str("\\SOx");
		send_str("\\SO");
		send_str("\\q");
		send_str("\\Qab");
		send_str("\\");
		send_str("\\N");

		while (chars_sent < 150)
			send_random_string();

		// sender waits for everything, then floods while the output is held
		drain();
		hold_req = 1'b1;
		while (!hold_active)
			@(posedge clk);
		calm = 1'b1;
		while (chars_sent < 200)
			send_random_string();
		calm = 1'b0;

		while (chars_sent < 330)
			send_random_string();
		calm = 1'b1;
		while (chars_sent < 400)
			send_random_string();
		calm = 1'b0;
		while (chars_sent < 460)
			send_random_string();

		drain();
		repeat (8) @(posedge clk);
		$display("%0d characters in %0d strings, %0d result words checked, %0d of them errors",
			chars_taken, strings_sent, words_checked, err_words);
		$display("input gaps, output stalls, a %0d-cycle output hold and drain pauses",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("haskell_string_unescape verification clean");
		else
			$display("haskell_string_unescape verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/hsu_pkg.sv
hdl/hsu_front.sv
hdl/hsu_queue.sv
hdl/hsu_back.sv
hdl/haskell_string_unescape.sv
tb/hsu_decode_check.sv
tb/tb_top.sv
